[hdl/pwc_pkg.sv]
// Shared types, constants and the divide step for the pulse width capture block.
package pwc_pkg;

	localparam int unsigned TIMEOUT_W = 31;
	localparam int unsigned RATE_W    = 8;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned WIDTH_W   = 31;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned DIV_STEPS = CNT_W / RATE_W;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_ACTIVE_LEVEL  = 2'd0;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_US    = 2'd1;
	localparam logic [IDX_W-1:0] REG_CYCLES_PER_US = 2'd2;

	localparam logic                 RST_ACTIVE_LEVEL  = 1'b1;
	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_US    = 31'd1000000;
	localparam logic [RATE_W-1:0]    RST_CYCLES_PER_US = 8'd80;

	// largest timeout in cycles before the microsecond limit kicks in
	localparam logic [TIMEOUT_W-1:0] MAX_CYCLES = 31'h7FFF_FFFF;

	// one item on its way through the divider
	typedef struct packed {
		logic [RATE_W-1:0] rem;
		logic [CNT_W-1:0]  num;
		logic [CNT_W-1:0]  quo;
		logic [RATE_W-1:0] dvs;
		logic              tmo;
	} pwc_div_t;

	typedef struct packed {
		logic [RATE_W-1:0] rem;
		logic [RATE_W-1:0] quo;
	} pwc_step_t;

	// eight restoring divide steps: rem < dvs on entry, dvs nonzero
	function automatic pwc_step_t div_step8(input logic [RATE_W-1:0] rem_in,
			input logic [RATE_W-1:0] bits, input logic [RATE_W-1:0] dvs);
		pwc_step_t     res;
		logic [RATE_W:0] trial;
		res.rem = rem_in;
		res.quo = '0;
		for (int i = RATE_W - 1; i >= 0; i--) begin
			trial = {res.rem, bits[i]};
			if (trial >= {1'b0, dvs}) begin
				trial      = trial - {1'b0, dvs};
				res.quo[i] = 1'b1;
			end
			res.rem = trial[RATE_W-1:0];
		end
		return res;
	endfunction

endpackage

[hdl/pwc_if.sv]
// Channel interfaces for pin samples and measured widths.
interface pwc_sample_if;
	logic valid;
	logic ready;
	logic start_req;
	logic pin_level;

	modport source (output valid, output start_req, output pin_level, input ready);
	modport sink   (input valid, input start_req, input pin_level, output ready);
endinterface

interface pwc_result_if;
	import pwc_pkg::*;
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] width_us;
	logic               timed_out;

	modport source (output valid, output width_us, output timed_out, input ready);
	modport sink   (input valid, input width_us, input timed_out, output ready);
endinterface

[hdl/pulse_width_capture_top.sv]
// Top level of the pulse width capture block.
//
// Usage: one sample transaction per clock tick carries start_req and
// pin_level. A start arms a measurement: wait for the inactive level, then
// the active level, then count the active pulse until the pin drops back.
// The width leaves on the result channel as floor(cycles / cycles_per_us)
// microseconds with timed_out low. If the cycles since start pass the
// timeout (clamped to the largest rate multiple within 31 bits) a result of
// width 0 with timed_out high leaves instead. Configuration goes through
// wr_en / wr_index / wr_data; indexes beyond the register list are dropped.
//
// Throughput: one sample per cycle while the first divider stage can take a
// result. A result loads into the first divider stage and then passes the
// four divide stages, eight quotient bits per stage, to the result channel.
// When the receiver stalls, results hold in the divider stages; sample
// transactions are still taken until the first stage is full and cannot
// move on. Reset returns the registers to their defaults, drops any
// running measurement and empties the divider.
module pulse_width_capture_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [pwc_pkg::IDX_W-1:0] wr_index,
	input  logic [pwc_pkg::TIMEOUT_W-1:0] wr_data,
	pwc_sample_if.sink                sample,
	pwc_result_if.source              result
);
	import pwc_pkg::*;

	localparam logic [1:0] PH_IDLE          = 2'd0;
	localparam logic [1:0] PH_WAIT_INACTIVE = 2'd1;
	localparam logic [1:0] PH_WAIT_ACTIVE   = 2'd2;
	localparam logic [1:0] PH_PULSE         = 2'd3;

	localparam int unsigned NSTG = DIV_STEPS + 1;

	// configuration registers
	logic                 active_level_q;
	logic [TIMEOUT_W-1:0] timeout_us_q;
	logic [RATE_W-1:0]    cycles_per_us_q;

	// measurement state
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] elapsed_q;
	logic [CNT_W-1:0] pulse_q;

	// background remainder of MAX_CYCLES by the rate
	logic [1:0]        mod_cnt_q;
	logic [RATE_W-1:0] mod_rem_q;
	logic [RATE_W-1:0] mod_dvs_q;
	logic [RATE_W-1:0] mod_res_q;

	// divider stages; the last one is the output register
	pwc_div_t div_s     [NSTG];
	logic     div_vld_s [NSTG];
	logic     adv       [NSTG];

	logic [RATE_W-1:0]          rate_eff;
	logic [TIMEOUT_W+RATE_W-1:0] tmo_prod;
	logic [CNT_W-1:0]           tmo_cycles;
	logic                       accept;

	logic [1:0]       phase_n;
	logic [CNT_W-1:0] elapsed_n;
	logic [CNT_W-1:0] pulse_n;
	logic             res_vld;
	logic             res_tmo;

	pwc_step_t        mod_step;
	logic [CNT_W-1:0] max_word;

	// a rate of zero behaves as one
	assign rate_eff = (cycles_per_us_q == '0) ? RATE_W'(1) : cycles_per_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q  <= RST_ACTIVE_LEVEL;
			timeout_us_q    <= RST_TIMEOUT_US;
			cycles_per_us_q <= RST_CYCLES_PER_US;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ACTIVE_LEVEL:  active_level_q  <= wr_data[0];
				REG_TIMEOUT_US:    timeout_us_q    <= wr_data;
				REG_CYCLES_PER_US: cycles_per_us_q <= wr_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Remainder of MAX_CYCLES by the rate, eight bits a cycle, rerun forever.
	// It only matters once the elapsed count nears 2^31, far beyond its lag.
	assign max_word = {1'b0, MAX_CYCLES};

	always_comb begin
		logic [CNT_W-1:0] shifted;
		shifted  = max_word << {mod_cnt_q, 3'b000};
		mod_step = div_step8((mod_cnt_q == '0) ? '0 : mod_rem_q,
			shifted[CNT_W-1 -: RATE_W],
			(mod_cnt_q == '0) ? rate_eff : mod_dvs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
			mod_res_q <= '0;
		end else begin
			mod_cnt_q <= mod_cnt_q + 2'd1;
			if (mod_cnt_q == 2'd3) begin
				mod_res_q <= mod_step.rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		mod_rem_q <= mod_step.rem;
		if (mod_cnt_q == '0) begin
			mod_dvs_q <= rate_eff;
		end
	end

	// Timeout in cycles: timeout_us * rate, clamped to the largest multiple of
	// the rate that fits in 31 bits.
	assign tmo_prod = timeout_us_q * rate_eff;

	always_comb begin
		if (tmo_prod > (TIMEOUT_W + RATE_W)'(MAX_CYCLES)) begin
			tmo_cycles = CNT_W'(MAX_CYCLES) - CNT_W'(mod_res_q);
		end else begin
			tmo_cycles = tmo_prod[CNT_W-1:0];
		end
	end

	// Take a sample whenever the first divider stage can take a result.
	assign sample.ready = adv[0];
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		logic at_active;
		logic running;
		at_active = (sample.pin_level == active_level_q);
		running   = 1'b1;
		phase_n   = phase_q;
		elapsed_n = elapsed_q;
		pulse_n   = pulse_q;
		res_vld   = 1'b0;
		res_tmo   = 1'b0;
		if (sample.start_req) begin
			phase_n   = PH_WAIT_INACTIVE;
			elapsed_n = '0;
			pulse_n   = '0;
		end else if (phase_q != PH_IDLE) begin
			if (elapsed_q != '1) begin
				elapsed_n = elapsed_q + CNT_W'(1);
			end
			if (phase_q == PH_PULSE && pulse_q != '1) begin
				pulse_n = pulse_q + CNT_W'(1);
			end
		end else begin
			running = 1'b0;
		end

		if (running) begin
			unique case (phase_n)
				PH_WAIT_INACTIVE: begin
					if (!at_active) begin
						phase_n = PH_WAIT_ACTIVE;
						running = 1'b0;
					end
				end
				PH_WAIT_ACTIVE: begin
					if (at_active) begin
						phase_n = PH_PULSE;
						pulse_n = '0;
						running = 1'b0;
					end
				end
				PH_PULSE: begin
					if (!at_active) begin
						phase_n = PH_IDLE;
						res_vld = 1'b1;
						running = 1'b0;
					end
				end
				default: running = 1'b0;
			endcase
		end

		// still waiting: check the timeout against the updated count
		if (running && elapsed_n > tmo_cycles) begin
			phase_n = PH_IDLE;
			res_vld = 1'b1;
			res_tmo = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			pulse_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			elapsed_q <= elapsed_n;
			pulse_q   <= pulse_n;
		end
	end

	// Advance chain: a stage loads when it is empty or its content moves on.
	assign adv[NSTG-1] = !div_vld_s[NSTG-1] || result.ready;

	for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
		assign adv[k] = !div_vld_s[k] || adv[k+1];
	end

	// first stage: load the dividend, zero on timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv[0]) begin
			div_vld_s[0] <= accept && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			div_s[0].rem <= '0;
			div_s[0].num <= res_tmo ? '0 : pulse_n;
			div_s[0].quo <= '0;
			div_s[0].dvs <= rate_eff;
			div_s[0].tmo <= res_tmo;
		end
	end

	// each later stage retires eight quotient bits, most significant first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		pwc_step_t step;

		assign step = div_step8(div_s[k].rem, div_s[k].num[CNT_W-1-RATE_W*k -: RATE_W],
			div_s[k].dvs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k+1] <= 1'b0;
			end else if (adv[k+1]) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k+1]) begin
				div_s[k+1]     <= div_s[k];
				div_s[k+1].rem <= step.rem;
				div_s[k+1].quo[CNT_W-1-RATE_W*k -: RATE_W] <= step.quo;
			end
		end
	end

	assign result.valid     = div_vld_s[NSTG-1];
	assign result.width_us  = div_s[NSTG-1].quo[WIDTH_W-1:0];
	assign result.timed_out = div_s[NSTG-1].tmo;

endmodule
